// File: hdl/clnb_pkg.sv
// shared types, codes and constants of the character lcd nibble bus controller
`default_nettype none
package clnb_pkg;

   localparam int BATCH_MAX = 5;
   localparam int COUNT_W = $clog2(BATCH_MAX + 1);
   localparam int ATTEMPT_W = 10;
   localparam int SETTLE_W = 13;

   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_STATUS = 2'd2,
      KIND_INIT   = 2'd3
   } kind_type;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   localparam logic [1:0] CSR_TWO_LINE = 2'd0;
   localparam logic [1:0] CSR_TALL_FONT = 2'd1;
   localparam logic [1:0] CSR_POLL_ATTEMPTS = 2'd2;

   localparam logic [ATTEMPT_W-1:0] POLL_ATTEMPTS_RESET = 10'd999;
   localparam int BUSY_BIT = 7;

   localparam logic [3:0] RESET_NIBBLE = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
   localparam logic [SETTLE_W-1:0] SETTLE_FIRST_MS = 13'd4100;
   localparam logic [SETTLE_W-1:0] SETTLE_SECOND_MS = 13'd100;
   localparam logic [SETTLE_W-1:0] SETTLE_SHORT_MS = 13'd37;

   localparam logic [7:0] INSTR_FUNC_SET = 8'h20;
   localparam logic [7:0] CMD_LINES_BIT = 8'h08;
   localparam logic [7:0] CMD_FONT_BIT = 8'h04;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] INSTR_CLEAR = 8'h01;
   localparam logic [7:0] CMD_ENTRY_INC = 8'h06;

   localparam logic [2:0] STAGE_NONE = 3'd0;
   localparam logic [2:0] STAGE_FUNCTION = 3'd1;
   localparam logic [2:0] STAGE_DISPLAY = 3'd2;
   localparam logic [2:0] STAGE_CLEAR = 3'd3;

   typedef struct packed {
      logic                 two_line;
      logic                 tall_font;
      logic [ATTEMPT_W-1:0] poll_attempts;
   } cfg_type;

   typedef struct packed {
      logic                action;
      logic                reg_select;
      logic [3:0]          nibble;
      logic [SETTLE_W-1:0] settle_ms;
      logic                timed_out;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [BATCH_MAX-1:0] item;
      logic [COUNT_W-1:0]           count;
   } batch_type;

   function automatic logic [7:0] init_command(input logic [2:0] stage,
                                               input logic two_line,
                                               input logic tall_font);
      logic [7:0] cmd;
      case (stage)
         STAGE_FUNCTION: begin
            cmd = INSTR_FUNC_SET | (two_line ? CMD_LINES_BIT : 8'h00)
                  | (tall_font ? CMD_FONT_BIT : 8'h00);
         end
         STAGE_DISPLAY: cmd = CMD_DISPLAY_OFF;
         STAGE_CLEAR: cmd = INSTR_CLEAR;
         default: cmd = CMD_ENTRY_INC;
      endcase
      return cmd;
   endfunction

   function automatic rsp_item_type status_read();
      rsp_item_type r;
      r = '0;
      r.action = ACT_READ;
      return r;
   endfunction

   function automatic rsp_item_type nibble_write(input logic rs,
                                                 input logic [3:0] nib,
                                                 input logic [SETTLE_W-1:0] settle,
                                                 input logic tmo);
      rsp_item_type r;
      r = '0;
      r.action = ACT_WRITE;
      r.reg_select = rs;
      r.nibble = nib;
      r.settle_ms = settle;
      r.timed_out = tmo;
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/clnb_if.sv
// request and result channel interfaces
`default_nettype none
interface clnb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;

   modport source(output valid, kind, value, input ready);
   modport sink(input valid, kind, value, output ready);
endinterface

interface clnb_rsp_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic        reg_select;
   logic [3:0]  nibble;
   logic [12:0] settle_ms;
   logic        timed_out;
   logic        last;

   modport source(output valid, action, reg_select, nibble, settle_ms, timed_out, last,
                  input ready);
   modport sink(input valid, action, reg_select, nibble, settle_ms, timed_out, last,
                output ready);
endinterface
`default_nettype wire

// File: hdl/clnb_csr.sv
// configuration registers
`default_nettype none
module clnb_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [clnb_pkg::ATTEMPT_W-1:0] csr_wdata,
   output clnb_pkg::cfg_type                  cfg
);

   clnb_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            clnb_pkg::CSR_TWO_LINE: cfg_in.two_line = csr_wdata[0];
            clnb_pkg::CSR_TALL_FONT: cfg_in.tall_font = csr_wdata[0];
            clnb_pkg::CSR_POLL_ATTEMPTS: cfg_in.poll_attempts = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.two_line <= 1'b0;
         cfg_ff.tall_font <= 1'b0;
         cfg_ff.poll_attempts <= clnb_pkg::POLL_ATTEMPTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: hdl/clnb_seq.sv
// input register, transfer state and per-item result batch
`default_nettype none
module clnb_seq (
   input  wire logic          clock,
   input  wire logic          reset,
   clnb_req_if.sink           req_chan,
   input  clnb_pkg::cfg_type  cfg,
   input  wire logic          drain_free,
   output wire logic          batch_load,
   output clnb_pkg::batch_type batch
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_kind_ff;
   logic [7:0] in_value_ff;
   logic       accept, go;

   logic                           pend_ff, pend_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           is_data_ff, is_data_in;
   logic [clnb_pkg::ATTEMPT_W-1:0] att_ff, att_in;
   logic [2:0]                     stage_ff, stage_in;

   logic [clnb_pkg::ATTEMPT_W-1:0] first_left;
   logic                           busy;
   clnb_pkg::batch_type            b;

   assign go = in_valid_ff && drain_free;
   assign req_chan.ready = !in_valid_ff || go;
   assign accept = req_chan.valid && req_chan.ready;
   assign in_valid_in = accept ? 1'b1 : (go ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_chan.kind;
         in_value_ff <= req_chan.value;
      end
   end

   // reads still allowed after the first status read of a transfer
   assign first_left = (cfg.poll_attempts == '0) ? '0 : cfg.poll_attempts - 1'b1;
   assign busy = in_value_ff[clnb_pkg::BUSY_BIT];

   always_comb begin
      pend_in = pend_ff;
      byte_in = byte_ff;
      is_data_in = is_data_ff;
      att_in = att_ff;
      stage_in = stage_ff;
      b = '0;
      case (in_kind_ff)
         clnb_pkg::KIND_CMD, clnb_pkg::KIND_DATA: begin
            if (!pend_ff) begin
               pend_in = 1'b1;
               byte_in = in_value_ff;
               is_data_in = (in_kind_ff == clnb_pkg::KIND_DATA);
               att_in = first_left;
               b.item[0] = clnb_pkg::status_read();
               b.count = 3'd1;
            end
         end
         clnb_pkg::KIND_INIT: begin
            if (!pend_ff) begin
               b.item[0] = clnb_pkg::nibble_write(1'b0, clnb_pkg::RESET_NIBBLE,
                                                  clnb_pkg::SETTLE_FIRST_MS, 1'b0);
               b.item[1] = clnb_pkg::nibble_write(1'b0, clnb_pkg::RESET_NIBBLE,
                                                  clnb_pkg::SETTLE_SECOND_MS, 1'b0);
               b.item[2] = clnb_pkg::nibble_write(1'b0, clnb_pkg::RESET_NIBBLE,
                                                  clnb_pkg::SETTLE_SHORT_MS, 1'b0);
               b.item[3] = clnb_pkg::nibble_write(1'b0, clnb_pkg::FOUR_BIT_NIBBLE,
                                                  clnb_pkg::SETTLE_SHORT_MS, 1'b0);
               b.item[4] = clnb_pkg::status_read();
               b.count = 3'd5;
               stage_in = clnb_pkg::STAGE_FUNCTION;
               pend_in = 1'b1;
               byte_in = clnb_pkg::init_command(clnb_pkg::STAGE_FUNCTION, cfg.two_line,
                                                cfg.tall_font);
               is_data_in = 1'b0;
               att_in = first_left;
            end
         end
         clnb_pkg::KIND_STATUS: begin
            if (pend_ff) begin
               if (busy && att_ff != '0) begin
                  att_in = att_ff - 1'b1;
                  b.item[0] = clnb_pkg::status_read();
                  b.count = 3'd1;
               end else begin
                  b.item[0] = clnb_pkg::nibble_write(is_data_ff, byte_ff[7:4], '0, busy);
                  b.item[1] = clnb_pkg::nibble_write(is_data_ff, byte_ff[3:0], '0, busy);
                  b.count = 3'd2;
                  pend_in = 1'b0;
                  is_data_in = 1'b0;
                  att_in = '0;
                  if (stage_ff >= clnb_pkg::STAGE_FUNCTION
                      && stage_ff <= clnb_pkg::STAGE_CLEAR) begin
                     // next init command starts polling right away
                     stage_in = stage_ff + 1'b1;
                     pend_in = 1'b1;
                     byte_in = clnb_pkg::init_command(stage_ff + 1'b1, cfg.two_line,
                                                      cfg.tall_font);
                     att_in = first_left;
                     b.item[2] = clnb_pkg::status_read();
                     b.count = 3'd3;
                  end else begin
                     stage_in = clnb_pkg::STAGE_NONE;
                  end
               end
            end
         end
         default: b = '0;
      endcase
      for (int i = 0; i < clnb_pkg::BATCH_MAX; i++) begin
         b.item[i].last = (b.count == clnb_pkg::COUNT_W'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         byte_ff <= '0;
         is_data_ff <= 1'b0;
         att_ff <= '0;
         stage_ff <= clnb_pkg::STAGE_NONE;
      end else if (go) begin
         pend_ff <= pend_in;
         byte_ff <= byte_in;
         is_data_ff <= is_data_in;
         att_ff <= att_in;
         stage_ff <= stage_in;
      end
   end

   assign batch = b;
   assign batch_load = go && (b.count != '0);

endmodule
`default_nettype wire

// File: hdl/clnb_drain.sv
// result buffer, one bus operation per cycle while the response channel is ready
`default_nettype none
module clnb_drain (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           batch_load,
   input  clnb_pkg::batch_type batch,
   output wire logic           drain_free,
   clnb_rsp_if.source          rsp_chan
);

   clnb_pkg::rsp_item_type entries_ff [clnb_pkg::BATCH_MAX];
   logic [clnb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [clnb_pkg::COUNT_W-1:0] ptr_ff, ptr_in;
   clnb_pkg::rsp_item_type cur;
   logic pop, pop_last;

   assign cur = entries_ff[ptr_ff];
   assign rsp_chan.valid = (count_ff != '0);
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign pop_last = pop && cur.last;
   assign drain_free = (count_ff == '0) || pop_last;

   always_comb begin
      count_in = count_ff;
      ptr_in = ptr_ff;
      if (batch_load) begin
         count_in = batch.count;
         ptr_in = '0;
      end else if (pop_last) begin
         count_in = '0;
         ptr_in = '0;
      end else if (pop) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (batch_load) begin
         for (int i = 0; i < clnb_pkg::BATCH_MAX; i++) begin
            entries_ff[i] <= batch.item[i];
         end
      end
   end

   assign rsp_chan.action = cur.action;
   assign rsp_chan.reg_select = cur.reg_select;
   assign rsp_chan.nibble = cur.nibble;
   assign rsp_chan.settle_ms = cur.settle_ms;
   assign rsp_chan.timed_out = cur.timed_out;
   assign rsp_chan.last = cur.last;

endmodule
`default_nettype wire

// File: hdl/char_lcd_nibble_bus_controller.sv
// top level of the character lcd 4-bit bus controller
// Each request item (command byte, data byte, status reply or init start) is
// registered, decoded in one pass into a batch of zero to five bus operations,
// and the batch is handed to a result buffer that presents one operation per
// cycle on the response channel while ready is high, the final one marked with
// last. The first operation appears after the item passes the input register
// and its batch is loaded into the result buffer. The next item waits until
// the buffer is empty or presents its final operation, so a longer batch (two
// or three operations for a finished transfer, five for init) holds it back.
// Items that yield nothing (a byte arriving mid-transfer, a stray status reply)
// load no batch. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module char_lcd_nibble_bus_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [clnb_pkg::ATTEMPT_W-1:0] csr_wdata,
   clnb_req_if.sink                            req_chan,
   clnb_rsp_if.source                          rsp_chan
);

   clnb_pkg::cfg_type   cfg;
   clnb_pkg::batch_type batch;
   logic                batch_load;
   logic                drain_free;

   clnb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   clnb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .drain_free (drain_free),
      .batch_load (batch_load),
      .batch      (batch)
   );

   clnb_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .batch_load (batch_load),
      .batch      (batch),
      .drain_free (drain_free),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
